// ===== design/round_robin_schedule_sim_top_defines.svh =====
// ----------------------------------------------------------------------------
// Round-robin scheduler: assertion macros
// Shared assertion forms used by the design files of the scheduler block.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SCHEDULE_SIM_TOP_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULE_SIM_TOP_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define RRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define RRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Record type of the process table and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int CLOCK_W = 21;
    localparam int WSUM_W  = 25;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX   = {CLOCK_W{1'b1}};
    localparam logic [WSUM_W-1:0]  WSUM_MAX    = {WSUM_W{1'b1}};
    localparam logic [TIME_W-1:0]  QUANTUM_RST = 16'd2;

    // One row of the process table.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  burst;
        logic [TIME_W-1:0]  remaining;
        logic [CLOCK_W-1:0] finish;
    } proc_rec_t;

endpackage

`default_nettype wire

// ===== design/round_robin_schedule_sim_top.sv =====
// ----------------------------------------------------------------------------
// Round-robin scheduling simulator
// Loads a set of processes, sorts them by arrival and simulates round-robin
// dispatch with a programmable quantum, then reports one result per process.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  load      load_valid / load_stall       process_id, arrival_time,
//                                          burst_time, last_process
//  result    result_valid / result_stall   result_id ... last_result
//  quantum   quantum_we                    quantum_wdata
//
// Load transactions are taken one per cycle while the block is idle.
// After the final load the block sorts the table by arrival (an exchange sort)
// and simulates dispatch and admission checks, all bounded by the single read
// port of the process table, then passes each result through a table read,
// an output load and presentation, held there by any stall, with result_valid
// high during presentation. load_stall stays high from the final load until
// the last result transaction has completed.
// Reset is asynchronous and active low; memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_schedule_sim_top #(
    parameter int MAX_PROCESSES = 16,
    localparam int IDX_W = $clog2(MAX_PROCESSES),
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  quantum_we,
    input  wire  [15:0]          quantum_wdata,
    input  wire                  load_valid,
    output logic                 load_stall,
    input  wire  [7:0]           process_id,
    input  wire  [15:0]          arrival_time,
    input  wire  [15:0]          burst_time,
    input  wire                  last_process,
    output logic                 result_valid,
    input  wire                  result_stall,
    output logic [7:0]           result_id,
    output logic [15:0]          arrival_out,
    output logic [15:0]          burst_out,
    output logic [20:0]          completion_time,
    output logic [20:0]          turnaround_time,
    output logic [20:0]          waiting_time,
    output logic [24:0]          total_wait,
    output logic [CNT_W-1:0]     process_count,
    output logic                 table_overflow,
    output logic                 last_result
);
    import rrs_pkg::*;
    `include "round_robin_schedule_sim_top_defines.svh"

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCESSES);

    typedef enum logic [17:0] {
        ST_IDLE      = 18'h00001,
        ST_SORT_I    = 18'h00002,
        ST_SORT_A    = 18'h00004,
        ST_SORT_B    = 18'h00008,
        ST_SORT_W    = 18'h00010,
        ST_SIM_START = 18'h00020,
        ST_SIM_INIT  = 18'h00040,
        ST_DISPATCH  = 18'h00080,
        ST_JUMP      = 18'h00100,
        ST_POP       = 18'h00200,
        ST_EXEC      = 18'h00400,
        ST_FIN       = 18'h00800,
        ST_ACC       = 18'h01000,
        ST_ADM_RD    = 18'h02000,
        ST_ADM_CK    = 18'h04000,
        ST_OUT_RD    = 18'h08000,
        ST_OUT_LD    = 18'h10000,
        ST_OUT_HOLD  = 18'h20000
    } state_t;

    // Waiting time from finish, arrival and burst; zero if it would go negative.
    function automatic logic [CLOCK_W-1:0] wait_of(
        input logic [CLOCK_W-1:0] fin,
        input logic [TIME_W-1:0]  arr,
        input logic [TIME_W-1:0]  bur
    );
        logic [CLOCK_W-1:0] tat;
        logic [CLOCK_W-1:0] bx;
        tat = fin - {{(CLOCK_W-TIME_W){1'b0}}, arr};
        bx  = {{(CLOCK_W-TIME_W){1'b0}}, bur};
        return (tat >= bx) ? tat - bx : '0;
    endfunction

    // Saturating advance of the simulated clock.
    function automatic logic [CLOCK_W-1:0] clk_add(
        input logic [CLOCK_W-1:0] c,
        input logic [TIME_W-1:0]  d
    );
        logic [CLOCK_W:0] s;
        s = {1'b0, c} + {{(CLOCK_W-TIME_W+1){1'b0}}, d};
        return s[CLOCK_W] ? CLOCK_MAX : s[CLOCK_W-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [TIME_W-1:0]  tq_reg, tq_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   nxt_reg, nxt_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic [CLOCK_W-1:0] clock_reg, clock_next;
    logic [WSUM_W-1:0]  wsum_reg, wsum_next;
    logic               pend_reg, pend_next;
    logic               oval_reg, oval_next;

    proc_rec_t          a_reg, a_next;
    proc_rec_t          cur_reg, cur_next;
    logic [IDX_W-1:0]   f_reg, f_next;
    logic [CLOCK_W-1:0] wt_reg, wt_next;

    logic [ID_W-1:0]    o_id_reg, o_id_next;
    logic [TIME_W-1:0]  o_arr_reg, o_arr_next;
    logic [TIME_W-1:0]  o_bur_reg, o_bur_next;
    logic [CLOCK_W-1:0] o_fin_reg, o_fin_next;
    logic [CLOCK_W-1:0] o_tat_reg, o_tat_next;
    logic [CLOCK_W-1:0] o_wt_reg, o_wt_next;
    logic               o_last_reg, o_last_next;

    // Table and queue controls
    logic               t_rd_en;
    logic [IDX_W-1:0]   t_rd_addr;
    proc_rec_t          t_rd_data;
    logic               t_wr_en;
    logic [IDX_W-1:0]   t_wr_addr;
    proc_rec_t          t_wr_data;
    logic               q_clear;
    logic               q_push;
    logic [IDX_W-1:0]   q_push_data;
    logic               q_pop;
    logic [IDX_W-1:0]   q_pop_data;
    logic [CNT_W-1:0]   q_count;

    logic [TIME_W-1:0]  quantum;
    logic               load_acc;
    logic [CNT_W-1:0]   cnt_after;
    proc_rec_t          rec_mod;

    assign quantum  = (tq_reg == '0) ? TIME_W'(1) : tq_reg;
    assign load_acc = load_valid && !load_stall;

    rrs_table #(.DEPTH(MAX_PROCESSES), .IDX_W(IDX_W)) u_table (
        .clk     (clk),
        .rd_en   (t_rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data)
    );

    rrs_queue #(.DEPTH(MAX_PROCESSES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (q_clear),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .count     (q_count)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        tq_next     = quantum_we ? quantum_wdata : tq_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        nxt_next    = nxt_reg;
        done_next   = done_reg;
        clock_next  = clock_reg;
        wsum_next   = wsum_reg;
        pend_next   = pend_reg;
        oval_next   = oval_reg;
        a_next      = a_reg;
        cur_next    = cur_reg;
        f_next      = f_reg;
        wt_next     = wt_reg;
        o_id_next   = o_id_reg;
        o_arr_next  = o_arr_reg;
        o_bur_next  = o_bur_reg;
        o_fin_next  = o_fin_reg;
        o_tat_next  = o_tat_reg;
        o_wt_next   = o_wt_reg;
        o_last_next = o_last_reg;

        t_rd_en     = 1'b0;
        t_rd_addr   = '0;
        t_wr_en     = 1'b0;
        t_wr_addr   = '0;
        t_wr_data   = a_reg;
        q_clear     = 1'b0;
        q_push      = 1'b0;
        q_push_data = '0;
        q_pop       = 1'b0;
        cnt_after   = cnt_reg;
        rec_mod     = t_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        t_wr_en   = 1'b1;
                        t_wr_addr = cnt_reg[IDX_W-1:0];
                        t_wr_data = '{id: process_id, arrival: arrival_time,
                                      burst: burst_time, remaining: burst_time,
                                      finish: '0};
                        cnt_after = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = cnt_after;
                    if (last_process)
                    begin
                        if (cnt_after == '0)
                        begin
                            ovf_next = 1'b0;
                            q_clear  = 1'b1;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = ST_SORT_I;
                        end
                    end
                end
            end
            ST_SORT_I:
            begin
                if (i_reg + 1'b1 < cnt_reg)
                begin
                    t_rd_en    = 1'b1;
                    t_rd_addr  = i_reg[IDX_W-1:0];
                    state_next = ST_SORT_A;
                end
                else
                begin
                    state_next = ST_SIM_START;
                end
            end
            ST_SORT_A:
            begin
                a_next     = t_rd_data;
                j_next     = i_reg + 1'b1;
                t_rd_en    = 1'b1;
                t_rd_addr  = j_next[IDX_W-1:0];
                state_next = ST_SORT_B;
            end
            ST_SORT_B:
            begin
                // Entry i lives in a_reg for the whole inner pass.
                if (t_rd_data.arrival < a_reg.arrival)
                begin
                    t_wr_en   = 1'b1;
                    t_wr_addr = j_reg[IDX_W-1:0];
                    t_wr_data = a_reg;
                    a_next    = t_rd_data;
                end
                j_next = j_reg + 1'b1;
                if (j_next < cnt_reg)
                begin
                    t_rd_en   = 1'b1;
                    t_rd_addr = j_next[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_SORT_W;
                end
            end
            ST_SORT_W:
            begin
                t_wr_en    = 1'b1;
                t_wr_addr  = i_reg[IDX_W-1:0];
                t_wr_data  = a_reg;
                i_next     = i_reg + 1'b1;
                state_next = ST_SORT_I;
            end
            ST_SIM_START:
            begin
                t_rd_en    = 1'b1;
                t_rd_addr  = '0;
                state_next = ST_SIM_INIT;
            end
            ST_SIM_INIT:
            begin
                clock_next  = {{(CLOCK_W-TIME_W){1'b0}}, t_rd_data.arrival};
                q_push      = 1'b1;
                q_push_data = '0;
                nxt_next    = CNT_W'(1);
                done_next   = '0;
                pend_next   = 1'b0;
                state_next  = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (done_reg == cnt_reg)
                begin
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else if (q_count == '0)
                begin
                    if (nxt_reg >= cnt_reg)
                    begin
                        i_next     = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        t_rd_en    = 1'b1;
                        t_rd_addr  = nxt_reg[IDX_W-1:0];
                        state_next = ST_JUMP;
                    end
                end
                else
                begin
                    q_pop      = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_JUMP:
            begin
                // Idle gap: move the clock up to the next pending arrival.
                if ({{(CLOCK_W-TIME_W){1'b0}}, t_rd_data.arrival} > clock_reg)
                begin
                    clock_next = {{(CLOCK_W-TIME_W){1'b0}}, t_rd_data.arrival};
                end
                pend_next  = 1'b0;
                state_next = ST_ADM_RD;
            end
            ST_POP:
            begin
                f_next     = q_pop_data;
                t_rd_en    = 1'b1;
                t_rd_addr  = q_pop_data;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (t_rd_data.remaining > quantum)
                begin
                    clock_next        = clk_add(clock_reg, quantum);
                    rec_mod.remaining = t_rd_data.remaining - quantum;
                    t_wr_en           = 1'b1;
                    t_wr_addr         = f_reg;
                    t_wr_data         = rec_mod;
                    pend_next         = 1'b1;
                    state_next        = ST_ADM_RD;
                end
                else
                begin
                    clock_next = clk_add(clock_reg, t_rd_data.remaining);
                    cur_next   = t_rd_data;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                rec_mod           = cur_reg;
                rec_mod.remaining = '0;
                rec_mod.finish    = clock_reg;
                t_wr_en           = 1'b1;
                t_wr_addr         = f_reg;
                t_wr_data         = rec_mod;
                wt_next           = wait_of(clock_reg, cur_reg.arrival, cur_reg.burst);
                done_next         = done_reg + 1'b1;
                state_next        = ST_ACC;
            end
            ST_ACC:
            begin
                wsum_next  = ({1'b0, wsum_reg} + {{(WSUM_W-CLOCK_W+1){1'b0}}, wt_reg})
                             > {1'b0, WSUM_MAX}
                             ? WSUM_MAX
                             : wsum_reg + {{(WSUM_W-CLOCK_W){1'b0}}, wt_reg};
                pend_next  = 1'b0;
                state_next = ST_ADM_RD;
            end
            ST_ADM_RD:
            begin
                if (nxt_reg < cnt_reg)
                begin
                    t_rd_en    = 1'b1;
                    t_rd_addr  = nxt_reg[IDX_W-1:0];
                    state_next = ST_ADM_CK;
                end
                else
                begin
                    q_push      = pend_reg;
                    q_push_data = f_reg;
                    pend_next   = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_ADM_CK:
            begin
                // Sorted table: arrivals are admitted strictly in index order.
                if ({{(CLOCK_W-TIME_W){1'b0}}, t_rd_data.arrival} <= clock_reg)
                begin
                    q_push      = 1'b1;
                    q_push_data = nxt_reg[IDX_W-1:0];
                    nxt_next    = nxt_reg + 1'b1;
                    state_next  = ST_ADM_RD;
                end
                else
                begin
                    q_push      = pend_reg;
                    q_push_data = f_reg;
                    pend_next   = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_OUT_RD:
            begin
                t_rd_en    = 1'b1;
                t_rd_addr  = i_reg[IDX_W-1:0];
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                o_id_next   = t_rd_data.id;
                o_arr_next  = t_rd_data.arrival;
                o_bur_next  = t_rd_data.burst;
                o_fin_next  = t_rd_data.finish;
                o_tat_next  = t_rd_data.finish
                              - {{(CLOCK_W-TIME_W){1'b0}}, t_rd_data.arrival};
                o_wt_next   = wait_of(t_rd_data.finish, t_rd_data.arrival,
                                      t_rd_data.burst);
                o_last_next = (i_reg + 1'b1 == cnt_reg);
                oval_next   = 1'b1;
                state_next  = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                if (!result_stall)
                begin
                    oval_next = 1'b0;
                    if (o_last_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        clock_next = '0;
                        wsum_next  = '0;
                        done_next  = '0;
                        q_clear    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            tq_reg    <= QUANTUM_RST;
            i_reg     <= '0;
            j_reg     <= '0;
            nxt_reg   <= '0;
            done_reg  <= '0;
            clock_reg <= '0;
            wsum_reg  <= '0;
            pend_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            tq_reg    <= tq_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            nxt_reg   <= nxt_next;
            done_reg  <= done_next;
            clock_reg <= clock_next;
            wsum_reg  <= wsum_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        cur_reg    <= cur_next;
        f_reg      <= f_next;
        wt_reg     <= wt_next;
        o_id_reg   <= o_id_next;
        o_arr_reg  <= o_arr_next;
        o_bur_reg  <= o_bur_next;
        o_fin_reg  <= o_fin_next;
        o_tat_reg  <= o_tat_next;
        o_wt_reg   <= o_wt_next;
        o_last_reg <= o_last_next;
    end

    // The whole set is held in the table while results drain, so sums and
    // counts stay stable across every result transaction of the run.
    assign load_stall      = (state_reg != ST_IDLE);
    assign result_valid    = oval_reg;
    assign result_id       = o_id_reg;
    assign arrival_out     = o_arr_reg;
    assign burst_out       = o_bur_reg;
    assign completion_time = o_fin_reg;
    assign turnaround_time = o_tat_reg;
    assign waiting_time    = o_wt_reg;
    assign total_wait      = wsum_reg;
    assign process_count   = cnt_reg;
    assign table_overflow  = ovf_reg;
    assign last_result     = o_last_reg;

    `RRS_ASSERT_NOW(a_result_blocks_load, clk, rst_n, oval_reg, load_stall,
        "load accepted while results pending")
    `RRS_ASSERT_NOW(a_done_bound, clk, rst_n, 1'b1, done_reg <= cnt_reg,
        "more completions than processes")
    `RRS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= MAX_CNT,
        "process count beyond table depth")

endmodule

`default_nettype wire

// ===== design/rrs_table.sv =====
// ----------------------------------------------------------------------------
// Process table
// Synchronous memory of process records, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire                      clk,
    input  wire                      rd_en,
    input  wire  [IDX_W-1:0]         rd_addr,
    output rrs_pkg::proc_rec_t       rd_data,
    input  wire                      wr_en,
    input  wire  [IDX_W-1:0]         wr_addr,
    input  rrs_pkg::proc_rec_t       wr_data
);
    import rrs_pkg::*;

    proc_rec_t mem [DEPTH];
    proc_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/rrs_queue.sv =====
// ----------------------------------------------------------------------------
// Ready queue
// Circular FIFO of table indices held in a synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_queue #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              clear,
    input  wire              push,
    input  wire  [IDX_W-1:0] push_data,
    input  wire              pop,
    output logic [IDX_W-1:0] pop_data,
    output logic [CNT_W-1:0] count
);
    `include "round_robin_schedule_sim_top_defines.svh"

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pop_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (push)
            begin
                tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop)
        begin
            pop_data_reg <= mem[head_reg];
        end
    end

    assign pop_data = pop_data_reg;
    assign count    = count_reg;

    `RRS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT,
        "ready queue count exceeds depth")
    `RRS_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, count_reg != '0,
        "pop from empty ready queue")
    `RRS_ASSERT_NEXT(a_clear_empty, clk, rst_n, clear, count_reg == '0,
        "ready queue not empty after clear")

endmodule

`default_nettype wire

// ===== dv/round_robin_schedule_sim_top_test.sv =====
// ----------------------------------------------------------------------------
// Round-robin scheduler testbench
// Loads process sets through the load channel, predicts the round-robin
// schedule of each set and checks every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_schedule_sim_top_test;

    localparam int MAXP      = 16;
    localparam int CYCLE_CAP = 400000000;

    // One expected result of a scheduled set.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [20:0] completion;
        logic [20:0] turnaround;
        logic [20:0] waiting;
        logic [24:0] total;
        logic [4:0]  count;
        logic        overflow;
        logic        last;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        quantum_we;
    logic [15:0] quantum_wdata;
    logic        load_valid;
    logic        load_stall;
    logic [7:0]  process_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic        last_process;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  result_id;
    logic [15:0] arrival_out;
    logic [15:0] burst_out;
    logic [20:0] completion_time;
    logic [20:0] turnaround_time;
    logic [20:0] waiting_time;
    logic [24:0] total_wait;
    logic [4:0]  process_count;
    logic        table_overflow;
    logic        last_result;

    // Predictor state: the pending set and the quantum as last written.
    logic [7:0]  set_id [MAXP];
    logic [15:0] set_arr [MAXP];
    logic [15:0] set_burst [MAXP];
    int          set_size;
    bit          set_dropped;
    logic [15:0] quantum_shadow;

    sched_result_t expected_results[$];
    int  fail_count;
    int  cycle_count;
    bit  hold_off;        // long receiver hold-off, driven by its own process
    bit  quiet_sender;    // no idling on the load side when set

    round_robin_schedule_sim_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .quantum_we      (quantum_we),
        .quantum_wdata   (quantum_wdata),
        .load_valid      (load_valid),
        .load_stall      (load_stall),
        .process_id      (process_id),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .last_process    (last_process),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_id       (result_id),
        .arrival_out     (arrival_out),
        .burst_out       (burst_out),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .total_wait      (total_wait),
        .process_count   (process_count),
        .table_overflow  (table_overflow),
        .last_result     (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is bounded by a cycle counter rather than by wall time.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Gap length on either side: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Works out the whole schedule of the pending set and queues its results.
    task automatic schedule_set();
        logic [7:0]  ids [MAXP];
        logic [15:0] arr [MAXP];
        logic [15:0] bur [MAXP];
        int unsigned rem [MAXP];
        int unsigned fin [MAXP];
        bit          queued [MAXP];
        int          fifo[$];
        int unsigned q, now, wsum, tat, wt;
        int          n, done, k, f;
        logic [15:0] tmp16;
        logic [7:0]  tmp8;
        sched_result_t r;

        n = set_size;
        if (n == 0)
        begin
            set_dropped = 0;
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            ids[i] = set_id[i];
            arr[i] = set_arr[i];
            bur[i] = set_burst[i];
            queued[i] = 0;
        end
        // Exchange sort: a swap only on a strictly earlier arrival.
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (arr[j] < arr[i])
                begin
                    tmp16 = arr[i]; arr[i] = arr[j]; arr[j] = tmp16;
                    tmp16 = bur[i]; bur[i] = bur[j]; bur[j] = tmp16;
                    tmp8 = ids[i]; ids[i] = ids[j]; ids[j] = tmp8;
                end
        q = (quantum_shadow == 0) ? 1 : quantum_shadow;
        for (int i = 0; i < n; i++)
            rem[i] = bur[i];
        now = arr[0];
        wsum = 0;
        done = 0;
        queued[0] = 1;
        fifo.push_back(0);
        while (done < n)
        begin
            if (fifo.size() == 0)
            begin
                // Idle gap: jump the clock to the first process not yet queued.
                k = 0;
                while (k < n && queued[k])
                    k++;
                if (k >= n)
                    break;
                if (arr[k] > now)
                    now = arr[k];
            end
            else
            begin
                f = fifo.pop_front();
                if (rem[f] > q)
                begin
                    now = now + q;
                    rem[f] = rem[f] - q;
                    // New arrivals go ahead of the preempted process.
                    for (int i = 0; i < n; i++)
                        if (!queued[i] && arr[i] <= now)
                        begin
                            queued[i] = 1;
                            fifo.push_back(i);
                        end
                    fifo.push_back(f);
                    continue;
                end
                now = now + rem[f];
                rem[f] = 0;
                fin[f] = now;
                tat = now - arr[f];
                wsum = wsum + ((tat >= bur[f]) ? tat - bur[f] : 0);
                done++;
            end
            for (int i = 0; i < n; i++)
                if (!queued[i] && arr[i] <= now)
                begin
                    queued[i] = 1;
                    fifo.push_back(i);
                end
        end
        for (int i = 0; i < n; i++)
        begin
            tat = fin[i] - arr[i];
            wt = (tat >= bur[i]) ? tat - bur[i] : 0;
            r.id = ids[i];
            r.arrival = arr[i];
            r.burst = bur[i];
            r.completion = 21'(fin[i]);
            r.turnaround = 21'(tat);
            r.waiting = 21'(wt);
            r.total = 25'(wsum);
            r.count = 5'(n);
            r.overflow = set_dropped;
            r.last = (i == n - 1);
            expected_results.push_back(r);
        end
        set_size = 0;
        set_dropped = 0;
    endtask

    // Sends one load transaction and updates the predictor once it is taken.
    task automatic send_process(input logic [7:0] pid, input logic [15:0] arr,
                                input logic [15:0] bur, input bit fin);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        repeat (gap)
        begin
            load_valid <= 1'b0;
            @(posedge clk);
        end
        load_valid <= 1'b1;
        process_id <= pid;
        arrival_time <= arr;
        burst_time <= bur;
        last_process <= fin;
        @(posedge clk);
        while (load_stall)
            @(posedge clk);
        // Transaction accepted at this edge; the next call drives the next one.
        if (set_size < MAXP)
        begin
            set_id[set_size] = pid;
            set_arr[set_size] = arr;
            set_burst[set_size] = bur;
            set_size++;
        end
        else
            set_dropped = 1;
        if (fin)
            schedule_set();
    endtask

    // Lowers valid after the last transaction of a stretch.
    task automatic release_load();
        load_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every expected result, then for the block to settle.
    task automatic drain_results();
        release_load();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes the quantum; only called with the block idle.
    task automatic write_quantum(input logic [15:0] value);
        quantum_we <= 1'b1;
        quantum_wdata <= value;
        @(posedge clk);
        quantum_we <= 1'b0;
        quantum_shadow = value;
        @(posedge clk);
    endtask

    // Random process set; arrivals are kept near each other most of the time
    // so that the queue stays busy and preemption happens often.
    task automatic random_set(input int n, input int span, input int bmax);
        for (int i = 0; i < n; i++)
            send_process(8'($urandom_range(0, 255)), 16'($urandom_range(0, span)),
                         16'($urandom_range(1, bmax)), i == n - 1);
    endtask

    // Extremes of every field, a single process and a zero burst.
    task automatic test_field_extremes();
        send_process(8'h00, 16'h0000, 16'h0001, 1'b1);
        send_process(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_process(8'hA5, 16'h0005, 16'h0000, 1'b0);
        send_process(8'h5A, 16'h0003, 16'h0007, 1'b0);
        send_process(8'h3C, 16'hFFFF, 16'h0001, 1'b1);
        drain_results();
    endtask

    // Equal arrivals, here swapped out of load order by the sort; idle gap between far arrivals.
    task automatic test_sort_and_idle_gap();
        send_process(8'd1, 16'd40, 16'd3, 1'b0);
        send_process(8'd2, 16'd10, 16'd5, 1'b0);
        send_process(8'd3, 16'd10, 16'd4, 1'b0);
        send_process(8'd4, 16'd1000, 16'd2, 1'b0);
        send_process(8'd5, 16'd0, 16'd9, 1'b1);
        drain_results();
    endtask

    // More loads than the table holds, the final one among those dropped.
    task automatic test_table_full();
        for (int i = 0; i < MAXP + 2; i++)
            send_process(8'(i), 16'($urandom_range(0, 20)), 16'($urandom_range(1, 8)),
                         i == MAXP + 1);
        drain_results();
    endtask

    // The quantum at its extremes, including zero which acts as one.
    task automatic test_quantum_settings();
        logic [15:0] settings [4];
        settings = '{16'd0, 16'd1, 16'hFFFF, 16'd3};
        foreach (settings[s])
        begin
            write_quantum(settings[s]);
            random_set(4, 10, 12);
            drain_results();
        end
    endtask

    // The receiver holds off while whole sets keep arriving.
    task automatic test_back_pressure();
        quiet_sender = 1;
        hold_off = 1;
        random_set(6, 30, 20);
        random_set(5, 30, 20);
        quiet_sender = 0;
        drain_results();
    endtask

    task automatic test_random_sets();
        int n, sent, quanta;
        sent = 0;
        quanta = 0;
        while (sent < 115)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                drain_results();
                write_quantum(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(1, 8)));
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 18)
                                             : $urandom_range(1, 8);
            if ($urandom_range(0, 4) == 0)
                random_set(n, 65535, 65535);
            else
                random_set(n, 40, 20);
            sent += n;
        end
        drain_results();
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                result_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Checks each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, id %0d", $time, result_id);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (e.id !== result_id || e.arrival !== arrival_out
                    || e.burst !== burst_out || e.completion !== completion_time
                    || e.turnaround !== turnaround_time || e.waiting !== waiting_time
                    || e.total !== total_wait || e.count !== process_count
                    || e.overflow !== table_overflow || e.last !== last_result)
                begin
                    $display("%0t: expected id %0d arr %0d bur %0d cmp %0d tat %0d wt %0d tot %0d cnt %0d ovf %0b last %0b",
                             $time, e.id, e.arrival, e.burst, e.completion, e.turnaround,
                             e.waiting, e.total, e.count, e.overflow, e.last);
                    $display("%0t: actual   id %0d arr %0d bur %0d cmp %0d tat %0d wt %0d tot %0d cnt %0d ovf %0b last %0b",
                             $time, result_id, arrival_out, burst_out, completion_time,
                             turnaround_time, waiting_time, total_wait, process_count,
                             table_overflow, last_result);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        quantum_we = 1'b0;
        quantum_wdata = '0;
        load_valid = 1'b0;
        process_id = '0;
        arrival_time = '0;
        burst_time = '0;
        last_process = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        hold_off = 0;
        quiet_sender = 0;
        set_size = 0;
        set_dropped = 0;
        quantum_shadow = 16'd2;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_sort_and_idle_gap();
        test_table_full();
        test_quantum_settings();
        test_back_pressure();
        test_random_sets();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== round_robin_schedule_sim_top.f =====
+incdir+design
design/rrs_pkg.sv
design/rrs_table.sv
design/rrs_queue.sv
design/round_robin_schedule_sim_top.sv
dv/round_robin_schedule_sim_top_test.sv
